>>> rtl/core/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
    localparam int PC_W          = 5;
    localparam int HOLD_W        = 14;
    localparam int DELAY_W       = 8;
    localparam int WAIT_PROD_W   = DELAY_W + DELAY_W + 1;

    localparam logic [HOLD_W-1:0]  HOLD_MAX         = {HOLD_W{1'b1}};
    localparam logic [DELAY_W-1:0] DELAY_RESET      = 8'd2;
    localparam logic [DELAY_W-1:0] POLL_LIMIT_RESET = 8'd250;

    typedef logic [PC_W-1:0]      pc_t;
    typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_BIT_DELAY  = 1'b0,
        REG_POLL_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        SDA_LOW,
        SDA_HIGH,
        SDA_PREV,
        SDA_TX,
        SDA_ACK
    } sda_sel_t;

    typedef enum logic [2:0] {
        HOLD_BIT,
        HOLD_ZERO,
        HOLD_HALF_LO,
        HOLD_HALF_HI,
        HOLD_WAIT
    } hold_sel_t;

    // one microcode word
    typedef struct packed {
        logic      scl;
        sda_sel_t  sda;
        hold_sel_t hold;
        logic      tx_shift;
        logic      rx_sample;
        logic      loop_bit;
        logic      br_timeout;
        logic      last;
        pc_t       target;
    } ucode_t;

    // program entry points
    localparam pc_t PC_START = 5'd0;
    localparam pc_t PC_STOP  = 5'd3;
    localparam pc_t PC_WRITE = 5'd6;
    localparam pc_t PC_READ  = 5'd12;

    function automatic pc_t entry_pc(input cmd_t cmd);
        pc_t pc;
        case (cmd)
            CMD_START: pc = PC_START;
            CMD_STOP:  pc = PC_STOP;
            CMD_WRITE: pc = PC_WRITE;
            CMD_READ:  pc = PC_READ;
            default:   pc = PC_START;
        endcase
        return pc;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/i2cm_rom.sv
`default_nettype none

module i2cm_rom
    import i2cm_pkg::*;
(
    input  pc_t    addr,
    output ucode_t word
);

    function automatic ucode_t uw(input logic scl, input sda_sel_t sda,
                                  input hold_sel_t hold, input logic tx_shift,
                                  input logic rx_sample, input logic loop_bit,
                                  input logic br_timeout, input logic last,
                                  input pc_t target);
        ucode_t w;
        w.scl        = scl;
        w.sda        = sda;
        w.hold       = hold;
        w.tx_shift   = tx_shift;
        w.rx_sample  = rx_sample;
        w.loop_bit   = loop_bit;
        w.br_timeout = br_timeout;
        w.last       = last;
        w.target     = target;
        return w;
    endfunction

    always_comb begin
        case (addr)
            // start
            5'd0:  word = uw(1'b1, SDA_HIGH, HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd1:  word = uw(1'b1, SDA_LOW,  HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd2:  word = uw(1'b0, SDA_LOW,  HOLD_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_START);
            // stop, also the tail of a timed-out write
            5'd3:  word = uw(1'b0, SDA_LOW,  HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd4:  word = uw(1'b1, SDA_LOW,  HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd5:  word = uw(1'b1, SDA_HIGH, HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_START);
            // write bit loop, release, ack wait
            5'd6:  word = uw(1'b0, SDA_PREV, HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd7:  word = uw(1'b0, SDA_TX,   HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd8:  word = uw(1'b1, SDA_TX,   HOLD_BIT,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, PC_WRITE);
            5'd9:  word = uw(1'b0, SDA_HIGH, HOLD_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd10: word = uw(1'b1, SDA_HIGH, HOLD_WAIT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, PC_STOP);
            5'd11: word = uw(1'b0, SDA_HIGH, HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_START);
            // read bit loop, sample at mid-high, then answer bit
            5'd12: word = uw(1'b0, SDA_HIGH, HOLD_BIT,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd13: word = uw(1'b1, SDA_HIGH, HOLD_HALF_LO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd14: word = uw(1'b1, SDA_HIGH, HOLD_HALF_HI, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, PC_READ);
            5'd15: word = uw(1'b0, SDA_HIGH, HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd16: word = uw(1'b0, SDA_ACK,  HOLD_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd17: word = uw(1'b1, SDA_ACK,  HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
            5'd18: word = uw(1'b0, SDA_ACK,  HOLD_BIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_START);
            default: word = uw(1'b1, SDA_HIGH, HOLD_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_START);
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/i2cm_seq.sv
`default_nettype none

module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  pc_t    start_pc,
    input  logic   step_en,
    input  ucode_t word,
    input  logic   timeout,
    output pc_t    pc,
    output logic   busy
);

    localparam bit_cnt_t LAST_BIT = bit_cnt_t'(BITS_PER_BYTE - 1);

    pc_t      pc_reg,      pc_next;
    bit_cnt_t bit_cnt_reg, bit_cnt_next;
    logic     busy_reg,    busy_next;

    always_comb begin
        pc_next      = pc_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        if (start) begin
            pc_next      = start_pc;
            bit_cnt_next = '0;
            busy_next    = 1'b1;
        end else if (step_en) begin
            pc_next = pc_reg + pc_t'(1);
            if (word.loop_bit) begin
                if (bit_cnt_reg != LAST_BIT) begin
                    pc_next      = word.target;
                    bit_cnt_next = bit_cnt_reg + bit_cnt_t'(1);
                end else begin
                    bit_cnt_next = '0;
                end
            end
            if (word.br_timeout && timeout) begin
                pc_next = word.target;
            end
            if (word.last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= PC_START;
            bit_cnt_reg <= '0;
            busy_reg    <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            bit_cnt_reg <= bit_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    assign pc   = pc_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> rtl/core/i2cm_dpath.sv
`default_nettype none

module i2cm_dpath
    import i2cm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  cmd_t                      command,
    input  logic [BITS_PER_BYTE-1:0]  tx_byte,
    input  logic                      send_ack,
    input  logic [BITS_PER_BYTE-1:0]  slave_bits,
    input  logic [DELAY_W-1:0]        ack_high_polls,
    input  logic [DELAY_W-1:0]        bit_delay,
    input  logic [DELAY_W-1:0]        poll_limit,
    input  logic                      step_en,
    input  ucode_t                    word,
    input  logic                      out_ready,
    output logic                      timeout,
    output logic                      out_valid,
    output logic                      scl_level,
    output logic                      sda_level,
    output logic [HOLD_W-1:0]         hold_us,
    output logic [BITS_PER_BYTE-1:0]  rx_byte,
    output logic                      nack_timeout,
    output logic                      last_phase
);

    logic [BITS_PER_BYTE-1:0] tx_reg, slave_reg, rx_reg;
    logic                     ack_bit_reg, timeout_reg, sda_prev_reg;
    logic [HOLD_W-1:0]        wait_hold_reg;

    logic                     out_valid_reg, scl_out_reg, sda_out_reg;
    logic [HOLD_W-1:0]        hold_out_reg;
    logic [BITS_PER_BYTE-1:0] rx_out_reg;
    logic                     nack_out_reg, last_out_reg;

    logic                     too_many;
    logic [DELAY_W-1:0]       polls_used;
    logic [WAIT_PROD_W-1:0]   wait_prod;
    logic [DELAY_W-1:0]       half_lo, half_hi;
    logic                     sda_val;
    logic [HOLD_W-1:0]        hold_val;

    // ack wait: (min(polls, limit) + 1) * delay, clipped
    assign too_many   = ack_high_polls > poll_limit;
    assign polls_used = too_many ? poll_limit : ack_high_polls;
    assign wait_prod  = WAIT_PROD_W'({1'b0, polls_used} + (DELAY_W+1)'(1))
                        * WAIT_PROD_W'(bit_delay);

    assign half_lo = bit_delay >> 1;
    assign half_hi = bit_delay - half_lo;

    always_comb begin
        case (word.sda)
            SDA_LOW:  sda_val = 1'b0;
            SDA_HIGH: sda_val = 1'b1;
            SDA_PREV: sda_val = sda_prev_reg;
            SDA_TX:   sda_val = tx_reg[BITS_PER_BYTE-1];
            SDA_ACK:  sda_val = ack_bit_reg;
            default:  sda_val = 1'b1;
        endcase
        case (word.hold)
            HOLD_BIT:     hold_val = HOLD_W'(bit_delay);
            HOLD_ZERO:    hold_val = '0;
            HOLD_HALF_LO: hold_val = HOLD_W'(half_lo);
            HOLD_HALF_HI: hold_val = HOLD_W'(half_hi);
            HOLD_WAIT:    hold_val = wait_hold_reg;
            default:      hold_val = '0;
        endcase
    end

    // item registers
    always_ff @(posedge aclk) begin
        if (load) begin
            tx_reg        <= tx_byte;
            slave_reg     <= slave_bits;
            rx_reg        <= '0;
            ack_bit_reg   <= ~send_ack;
            timeout_reg   <= (command == CMD_WRITE) && too_many;
            wait_hold_reg <= (wait_prod > WAIT_PROD_W'(HOLD_MAX)) ? HOLD_MAX
                                                                  : wait_prod[HOLD_W-1:0];
        end else if (step_en) begin
            if (word.tx_shift) begin
                tx_reg <= {tx_reg[BITS_PER_BYTE-2:0], 1'b0};
            end
            if (word.rx_sample) begin
                rx_reg    <= {rx_reg[BITS_PER_BYTE-2:0], slave_reg[BITS_PER_BYTE-1]};
                slave_reg <= {slave_reg[BITS_PER_BYTE-2:0], 1'b0};
            end
        end
    end

    // line state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sda_prev_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (step_en) begin
                sda_prev_reg  <= sda_val;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            scl_out_reg  <= word.scl;
            sda_out_reg  <= sda_val;
            hold_out_reg <= hold_val;
            // rx assembles fully before the last step of a read
            rx_out_reg   <= word.last ? rx_reg : '0;
            nack_out_reg <= word.last & timeout_reg;
            last_out_reg <= word.last;
        end
    end

    assign timeout      = timeout_reg;
    assign out_valid    = out_valid_reg;
    assign scl_level    = scl_out_reg;
    assign sda_level    = sda_out_reg;
    assign hold_us      = hold_out_reg;
    assign rx_byte      = rx_out_reg;
    assign nack_timeout = nack_out_reg;
    assign last_phase   = last_out_reg;

endmodule

`default_nettype wire

>>> rtl/core/i2c_master_bit_engine.sv
// An accepted beat loads the sequencer, whose first step then fills the result register.
// Throughput: one phase per cycle from the microcode, 3 to 29 phases per command; a stalled
//   result holds the sequencer.
// Reset: synchronous active-low aresetn; registers return to delay 2 and poll limit 250,
//   SDA is taken as released and no result is pending.
`default_nettype none

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // command beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_tx_byte,
    input  logic        s_send_ack,
    input  logic [7:0]  s_slave_bits,
    input  logic [7:0]  s_ack_high_polls,

    // bus phase beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_level,
    output logic [13:0] m_hold_us,
    output logic [7:0]  m_rx_byte,
    output logic        m_nack_timeout,
    output logic        m_last_phase,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register map: bit delay at 0x0, ack poll limit at 0x4; only paddr[2] decodes.
    logic [DELAY_W-1:0] bit_delay_reg, poll_limit_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_delay_reg  <= DELAY_RESET;
            poll_limit_reg <= POLL_LIMIT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BIT_DELAY:  bit_delay_reg  <= pwdata[DELAY_W-1:0];
                REG_POLL_LIMIT: poll_limit_reg <= pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BIT_DELAY:  prdata = {24'd0, bit_delay_reg};
            REG_POLL_LIMIT: prdata = {24'd0, poll_limit_reg};
            default:        prdata = '0;
        endcase
    end

    // Control: the sequencer walks the microcode; one word is executed per step and
    // its phase lands in the result register. A step only runs while that register
    // is empty or being drained, so a stalled result freezes the program.
    logic   busy, accept, step_en, timeout;
    pc_t    pc;
    ucode_t word;

    assign s_ready = ~busy;
    assign accept  = s_valid & s_ready;
    assign step_en = busy & (~m_valid | m_ready);

    i2cm_rom u_rom (
        .addr (pc),
        .word (word)
    );

    i2cm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .start_pc (entry_pc(cmd_t'(s_command))),
        .step_en  (step_en),
        .word     (word),
        .timeout  (timeout),
        .pc       (pc),
        .busy     (busy)
    );

    // Datapath: shifters for the byte out and in, the precomputed ack-wait hold
    // and the result register that parts the sequencer from the consumer.
    i2cm_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .command        (cmd_t'(s_command)),
        .tx_byte        (s_tx_byte),
        .send_ack       (s_send_ack),
        .slave_bits     (s_slave_bits),
        .ack_high_polls (s_ack_high_polls),
        .bit_delay      (bit_delay_reg),
        .poll_limit     (poll_limit_reg),
        .step_en        (step_en),
        .word           (word),
        .out_ready      (m_ready),
        .timeout        (timeout),
        .out_valid      (m_valid),
        .scl_level      (m_scl_level),
        .sda_level      (m_sda_level),
        .hold_us        (m_hold_us),
        .rx_byte        (m_rx_byte),
        .nack_timeout   (m_nack_timeout),
        .last_phase     (m_last_phase)
    );

endmodule

`default_nettype wire

>>> rtl/core/i2cm_checker.sv
`default_nettype none

module i2cm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_scl_level,
    input logic        m_sda_level,
    input logic [13:0] m_hold_us,
    input logic [7:0]  m_rx_byte,
    input logic        m_nack_timeout,
    input logic        m_last_phase
);

    // a stalled phase beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hold_us) && $stable(m_last_phase)
            && $stable(m_scl_level) && $stable(m_sda_level))
        else $error("phase beat changed while stalled");

    // no new command while one is mid-sequence
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_phase |-> !s_ready)
        else $error("command taken during a sequence");

    a_rx_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rx_byte != 8'd0 |-> m_last_phase)
        else $error("rx byte shown before the last phase");

    // a timed-out write ends on a stop: both lines released
    a_nack_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nack_timeout |-> m_last_phase && m_scl_level && m_sda_level)
        else $error("nack not on a stop phase");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_scl_level    (m_scl_level),
    .m_sda_level    (m_sda_level),
    .m_hold_us      (m_hold_us),
    .m_rx_byte      (m_rx_byte),
    .m_nack_timeout (m_nack_timeout),
    .m_last_phase   (m_last_phase)
);

`default_nettype wire

>>> dv/tb_i2c_master_bit_engine.sv
`default_nettype none

module tb_i2c_master_bit_engine;
    import i2cm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    logic aclk;
    logic aresetn = 1'b0;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known level
    // ------------------------------------------------------------------
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command        = 2'd0;
    logic [7:0]  s_tx_byte        = 8'd0;
    logic        s_send_ack       = 1'b0;
    logic [7:0]  s_slave_bits     = 8'd0;
    logic [7:0]  s_ack_high_polls = 8'd0;

    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic        m_scl_level;
    logic        m_sda_level;
    logic [13:0] m_hold_us;
    logic [7:0]  m_rx_byte;
    logic        m_nack_timeout;
    logic        m_last_phase;

    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [2:0]  paddr            = 3'd0;
    logic [31:0] pwdata           = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_bit_engine uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_tx_byte        (s_tx_byte),
        .s_send_ack       (s_send_ack),
        .s_slave_bits     (s_slave_bits),
        .s_ack_high_polls (s_ack_high_polls),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_scl_level      (m_scl_level),
        .m_sda_level      (m_sda_level),
        .m_hold_us        (m_hold_us),
        .m_rx_byte        (m_rx_byte),
        .m_nack_timeout   (m_nack_timeout),
        .m_last_phase     (m_last_phase),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------
    // Beat types
    // ------------------------------------------------------------------
    // one bus command as it goes onto the input channel
    typedef struct packed {
        cmd_t       command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic [7:0] slave_bits;
        logic [7:0] ack_high_polls;
    } bus_cmd_t;

    // one SCL/SDA bus phase as expected on the result channel
    typedef struct packed {
        logic        scl;
        logic        sda;
        logic [13:0] hold;
        logic [7:0]  rx;
        logic        nack;
        logic        last_ph;
    } bus_phase_t;

    bus_cmd_t   cmd_backlog[$];     // commands not yet offered
    bus_phase_t exp_phases[$];      // phases predicted but not yet seen
    bus_cmd_t   cmd_on_bus;         // command currently offered

    // predictor's own copy of the registers and of the driven SDA level
    logic [7:0] cfg_delay      = DELAY_RESET;
    logic [7:0] cfg_poll_limit = POLL_LIMIT_RESET;
    logic       bus_sda        = 1'b1;

    // no_idle gives stretches where neither side holds off
    logic       no_idle        = 1'b0;
    int         err_count      = 0;
    int         send_wait      = 0;
    int         recv_wait      = 0;

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void add_phase(input logic scl, input logic sda,
                                      input int unsigned hold);
        bus_phase_t p;
        p.scl     = scl;
        p.sda     = sda;
        // hold saturates at the top of the 14-bit field
        p.hold    = (hold > 32'(HOLD_MAX)) ? HOLD_MAX : hold[13:0];
        p.rx      = 8'd0;
        p.nack    = 1'b0;
        p.last_ph = 1'b0;
        exp_phases.push_back(p);
        bus_sda   = sda;
    endfunction

    function automatic void add_stop(input int unsigned d);
        add_phase(1'b0, 1'b0, d);
        add_phase(1'b1, 1'b0, d);
        add_phase(1'b1, 1'b1, d);
    endfunction

    function automatic void predict_bus_phases(input bus_cmd_t c);
        int unsigned d;
        int unsigned h1;
        logic        bit_val;
        logic        answer;
        logic [7:0]  rx;
        logic        nack;
        bus_phase_t  tail;
        d    = cfg_delay;
        h1   = d / 2;
        rx   = 8'd0;
        nack = 1'b0;
        case (c.command)
            CMD_START: begin
                add_phase(1'b1, 1'b1, d);
                add_phase(1'b1, 1'b0, d);
                add_phase(1'b0, 1'b0, 0);
            end
            CMD_STOP: begin
                add_stop(d);
            end
            CMD_WRITE: begin
                // MSB first; each bit opens on whatever SDA was left at
                for (int i = 7; i >= 0; i--) begin
                    bit_val = c.tx_byte[i];
                    add_phase(1'b0, bus_sda, d);
                    add_phase(1'b0, bit_val, d);
                    add_phase(1'b1, bit_val, d);
                end
                add_phase(1'b0, 1'b1, 0);
                // acknowledge wait is one merged phase
                if (c.ack_high_polls <= cfg_poll_limit) begin
                    add_phase(1'b1, 1'b1, (32'(c.ack_high_polls) + 1) * d);
                    add_phase(1'b0, 1'b1, d);
                end else begin
                    add_phase(1'b1, 1'b1, (32'(cfg_poll_limit) + 1) * d);
                    add_stop(d);
                    nack = 1'b1;
                end
            end
            default: begin
                // read: sample at mid-high, then ACK or NACK
                answer = ~c.send_ack;
                for (int i = 0; i < BITS_PER_BYTE; i++) begin
                    add_phase(1'b0, 1'b1, d);
                    add_phase(1'b1, 1'b1, h1);
                    add_phase(1'b1, 1'b1, d - h1);
                end
                rx = c.slave_bits;
                add_phase(1'b0, 1'b1, d);
                add_phase(1'b0, answer, 0);
                add_phase(1'b1, answer, d);
                add_phase(1'b0, answer, d);
            end
        endcase
        tail         = exp_phases.pop_back();
        tail.rx      = rx;
        tail.nack    = nack;
        tail.last_ph = 1'b1;
        exp_phases.push_back(tail);
    endfunction

    // ------------------------------------------------------------------
    // Command driver: offers one beat at a time from the backlog,
    // holding it steady until s_ready takes it
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            // the beat accepted at this edge is predicted here, while the
            // registers are known to be steady
            if (s_valid && s_ready)
                predict_bus_phases(cmd_on_bus);
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    s_valid   <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    cmd_on_bus        = cmd_backlog.pop_front();
                    s_command        <= cmd_on_bus.command;
                    s_tx_byte        <= cmd_on_bus.tx_byte;
                    s_send_ack       <= cmd_on_bus.send_ack;
                    s_slave_bits     <= cmd_on_bus.slave_bits;
                    s_ack_high_polls <= cmd_on_bus.ack_high_polls;
                    s_valid          <= 1'b1;
                    // gap to leave after this beat goes
                    send_wait        <= no_idle ? 0 : $urandom_range(0, 9);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Phase monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [13:0] got,
                               input logic [13:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge aclk) begin
        bus_phase_t want;
        int         stall;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (exp_phases.size() == 0) begin
                report_mismatch("bus phase beat with nothing expected");
            end else begin
                want = exp_phases.pop_front();
                check_field("scl_level",    14'(m_scl_level),    14'(want.scl));
                check_field("sda_level",    14'(m_sda_level),    14'(want.sda));
                check_field("hold_us",      m_hold_us,           want.hold);
                check_field("rx_byte",      14'(m_rx_byte),      14'(want.rx));
                check_field("nack_timeout", 14'(m_nack_timeout), 14'(want.nack));
                check_field("last_phase",   14'(m_last_phase),   14'(want.last_ph));
            end
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_ready   <= 1'b0;
                recv_wait <= stall;
            end
        end else if (!m_ready) begin
            if (recv_wait > 1)
                recv_wait <= recv_wait - 1;
            else
                m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic reg_write(input reg_idx_t idx, input logic [7:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BIT_DELAY)
            cfg_delay = val;
        else
            cfg_poll_limit = val;
    endtask

    task automatic set_timing(input logic [7:0] delay, input logic [7:0] limit);
        reg_write(REG_BIT_DELAY, delay);
        reg_write(REG_POLL_LIMIT, limit);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_cmd(input cmd_t c, input logic [7:0] tx,
                                     input logic ack, input logic [7:0] slave,
                                     input logic [7:0] polls);
        bus_cmd_t x;
        x.command        = c;
        x.tx_byte        = tx;
        x.send_ack       = ack;
        x.slave_bits     = slave;
        x.ack_high_polls = polls;
        cmd_backlog.push_back(x);
    endfunction

    // random content; polls lean on the limit so both ack outcomes show up
    function automatic void push_random(input cmd_t c);
        logic [7:0] polls;
        case ($urandom_range(0, 4))
            0:       polls = 8'd0;
            1:       polls = cfg_poll_limit;
            2:       polls = cfg_poll_limit + 8'd1;
            default: polls = 8'($urandom);
        endcase
        push_cmd(c, 8'($urandom), 1'($urandom), 8'($urandom), polls);
    endfunction

    // mostly well-formed transfers, with some stray commands mixed in
    task automatic queue_traffic(input int count);
        int n;
        int k;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 8) begin
                push_random(CMD_START);
                k = $urandom_range(1, 4);
                for (int j = 0; j < k; j++)
                    push_random(($urandom_range(0, 2) != 0) ? CMD_WRITE : CMD_READ);
                push_random(CMD_STOP);
                n += k + 2;
            end else begin
                push_random(cmd_t'($urandom_range(0, 3)));
                n++;
            end
        end
    endtask

    // sender holds back until every predicted phase has been seen
    task automatic wait_idle();
        int n;
        n = 0;
        while ((cmd_backlog.size() != 0 || s_valid || exp_phases.size() != 0)
               && n < 100000) begin
            @(posedge aclk);
            n++;
        end
        repeat (20) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset timing: delay 2, poll limit 250
        push_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 8'd0);
        push_cmd(CMD_WRITE, 8'hFF, 1'b0, 8'h00, 8'd0);      // ack on first poll
        push_cmd(CMD_WRITE, 8'h00, 1'b1, 8'hFF, 8'd250);    // ack right at the limit
        push_cmd(CMD_WRITE, 8'h5A, 1'b0, 8'h00, 8'd251);    // one past: timeout
        push_cmd(CMD_WRITE, 8'h80, 1'b1, 8'h00, 8'd255);    // timeout, widest polls
        push_cmd(CMD_WRITE, 8'h01, 1'b0, 8'h00, 8'd17);
        push_cmd(CMD_READ,  8'h00, 1'b1, 8'h00, 8'd0);      // all-zero byte, ACK
        push_cmd(CMD_READ,  8'hFF, 1'b0, 8'hFF, 8'd255);    // all-one byte, NACK
        push_cmd(CMD_READ,  8'h00, 1'b1, 8'hA5, 8'd0);
        push_cmd(CMD_STOP,  8'h00, 1'b0, 8'h00, 8'd0);
        push_cmd(CMD_STOP,  8'h00, 1'b0, 8'h00, 8'd0);
        push_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 8'd0);
        wait_idle();

        // zero bit delay and zero poll limit
        set_timing(8'd0, 8'd0);
        push_cmd(CMD_WRITE, 8'hC3, 1'b0, 8'h00, 8'd0);      // still acknowledged
        push_cmd(CMD_WRITE, 8'h3C, 1'b0, 8'h00, 8'd1);      // times out at once
        push_cmd(CMD_READ,  8'h00, 1'b1, 8'h96, 8'd0);
        push_cmd(CMD_STOP,  8'h00, 1'b0, 8'h00, 8'd0);
        wait_idle();

        // longest delay: merged ack wait hits saturation
        set_timing(8'd255, 8'd255);
        push_cmd(CMD_WRITE, 8'hAA, 1'b0, 8'h00, 8'd63);     // 64*255, just below the cap
        push_cmd(CMD_WRITE, 8'h55, 1'b0, 8'h00, 8'd64);     // just over, saturates
        push_cmd(CMD_WRITE, 8'hF0, 1'b0, 8'h00, 8'd255);
        push_cmd(CMD_READ,  8'h00, 1'b0, 8'h0F, 8'd0);      // odd delay splits unevenly
        push_cmd(CMD_STOP,  8'h00, 1'b0, 8'h00, 8'd0);
        wait_idle();

        // random traffic over several timing settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_timing(8'd1, 8'd0);
                1: set_timing(8'd255, 8'd255);
                2: set_timing(8'd0, 8'd200);
                3: set_timing(8'd3, 8'd1);
                4: set_timing(8'($urandom), 8'($urandom));
                5: set_timing(8'd128, 8'd127);
                default: set_timing(DELAY_RESET, POLL_LIMIT_RESET);
            endcase
            no_idle = (ph == 2 || ph == 5);
            queue_traffic(70);
            wait_idle();
        end

        if (exp_phases.size() != 0)
            report_mismatch($sformatf("%0d bus phases never arrived", exp_phases.size()));
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
